// ===== hdl/pios_pkg.sv =====
// Shared widths, constants, types and the arctangent table of the sector test.
`timescale 1ns / 1ps

package pios_pkg;

    // geometry
    localparam int COORD_BITS   = 24;
    localparam int CORDIC_STEPS = 16;
    localparam int DELTA_W      = COORD_BITS + 1;
    localparam int SQ_W         = 2 * COORD_BITS;
    localparam int D2_W         = SQ_W + 1;
    localparam int RADIUS_W     = 23;
    localparam int R2_W         = 2 * RADIUS_W;
    localparam int CMP_W        = (D2_W > R2_W) ? D2_W : R2_W;

    // CORDIC datapath: vectors pre-scaled so they start near bit 59
    localparam int CW           = 64;
    localparam int PRE_SHIFT    = 60 - DELTA_W;
    localparam int Z_W          = 25;
    localparam int ATAN_W       = 22;
    localparam int HEAD_W       = Z_W - 8;

    // angles, 1/256 degree
    localparam int FWD_W        = 18;
    localparam int APER_W       = 17;
    localparam int DIFF_W       = 19;
    localparam int WRAP_W       = 17;
    localparam int ABS_W        = WRAP_W - 1;

    localparam logic signed [Z_W-1:0]    Z_QUARTER = Z_W'(90 * 65536);
    localparam logic signed [Z_W-1:0]    Z_ROUND   = Z_W'(128);
    localparam logic signed [DIFF_W-1:0] HALF_TURN = DIFF_W'(46080);
    localparam logic signed [DIFF_W-1:0] FULL_TURN = DIFF_W'(92160);
    localparam logic signed [DIFF_W-1:0] TWO_TURNS = DIFF_W'(184320);

    // configuration port
    localparam int CFG_W     = (COORD_BITS > RADIUS_W) ? COORD_BITS : RADIUS_W;
    localparam int CFG_IDX_W = 3;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_APEX_X    = CFG_IDX_W'(0),
        REG_APEX_Y    = CFG_IDX_W'(1),
        REG_FORWARD   = CFG_IDX_W'(2),
        REG_APERTURE  = CFG_IDX_W'(3),
        REG_RADIUS    = CFG_IDX_W'(4)
    } t_reg_idx;

    // one item in flight through the rotation stages
    typedef struct packed {
        logic                  valid;
        logic                  in_rad;
        logic                  at_apex;
        logic signed [CW-1:0]  x;
        logic signed [CW-1:0]  y;
        logic signed [Z_W-1:0] z;
    } t_vec;

    // atan(2^-i) in 1/65536 degree
    function automatic logic signed [Z_W-1:0] f_atan(input int unsigned i);
        logic [ATAN_W-1:0] v;
        case (i)
            0:       v = ATAN_W'(2949120);
            1:       v = ATAN_W'(1740967);
            2:       v = ATAN_W'(919879);
            3:       v = ATAN_W'(466945);
            4:       v = ATAN_W'(234379);
            5:       v = ATAN_W'(117304);
            6:       v = ATAN_W'(58666);
            7:       v = ATAN_W'(29335);
            8:       v = ATAN_W'(14668);
            9:       v = ATAN_W'(7334);
            10:      v = ATAN_W'(3667);
            11:      v = ATAN_W'(1833);
            12:      v = ATAN_W'(917);
            13:      v = ATAN_W'(458);
            14:      v = ATAN_W'(229);
            15:      v = ATAN_W'(115);
            16:      v = ATAN_W'(57);
            17:      v = ATAN_W'(29);
            18:      v = ATAN_W'(14);
            19:      v = ATAN_W'(7);
            20:      v = ATAN_W'(4);
            21:      v = ATAN_W'(2);
            22:      v = ATAN_W'(1);
            default: v = '0;
        endcase
        return signed'(Z_W'(v));
    endfunction

endpackage

// ===== hdl/pios_front.sv =====
// Front stages: offset from apex, squares, radius check and quadrant fold.
`timescale 1ns / 1ps

module pios_front
    import pios_pkg::*;
(
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_valid,
    input  logic signed [COORD_BITS-1:0] i_point_x,
    input  logic signed [COORD_BITS-1:0] i_point_y,
    input  logic signed [COORD_BITS-1:0] i_apex_x,
    input  logic signed [COORD_BITS-1:0] i_apex_y,
    input  logic [RADIUS_W-1:0]          i_sector_radius,
    input  logic                         i_ready,
    output logic                         o_ready,
    output t_vec                         o_vec
);

    logic                      w_en_a, w_en_b, w_en_c;

    logic                      r_a_v;
    logic signed [DELTA_W-1:0] r_a_dx, r_a_dy;
    logic signed [DELTA_W-1:0] n_a_dx, n_a_dy;

    logic                      r_b_v;
    logic signed [DELTA_W-1:0] r_b_dx, r_b_dy;
    logic [SQ_W-1:0]           r_b_sx, r_b_sy;
    logic [R2_W-1:0]           r_b_r2;
    logic signed [2*DELTA_W-1:0] w_sx_full, w_sy_full;
    logic [R2_W-1:0]           w_r2;

    t_vec                      r_c, n_c;
    logic [D2_W-1:0]           w_d2;
    logic signed [CW-1:0]      w_x0, w_y0;

    assign w_en_c  = !r_c.valid || i_ready;
    assign w_en_b  = !r_b_v || w_en_c;
    assign w_en_a  = !r_a_v || w_en_b;
    assign o_ready = w_en_a;

    // stage A: difference vector
    assign n_a_dx = DELTA_W'(i_point_x) - DELTA_W'(i_apex_x);
    assign n_a_dy = DELTA_W'(i_point_y) - DELTA_W'(i_apex_y);

    // stage B: squares
    assign w_sx_full = r_a_dx * r_a_dx;
    assign w_sy_full = r_a_dy * r_a_dy;
    assign w_r2      = i_sector_radius * i_sector_radius;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_v <= 1'b0;
            r_b_v <= 1'b0;
        end else begin
            if (w_en_a) r_a_v <= i_valid;
            if (w_en_b) r_b_v <= r_a_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en_a) begin
            r_a_dx <= n_a_dx;
            r_a_dy <= n_a_dy;
        end
        if (w_en_b) begin
            r_b_dx <= r_a_dx;
            r_b_dy <= r_a_dy;
            r_b_sx <= w_sx_full[SQ_W-1:0];
            r_b_sy <= w_sy_full[SQ_W-1:0];
            r_b_r2 <= w_r2;
        end
    end

    // stage C: distance compare, scale up and fold into the right half plane
    assign w_d2 = D2_W'(r_b_sx) + D2_W'(r_b_sy);
    assign w_x0 = CW'(r_b_dx) <<< PRE_SHIFT;
    assign w_y0 = CW'(r_b_dy) <<< PRE_SHIFT;

    always_comb begin
        n_c.valid   = r_b_v;
        n_c.in_rad  = CMP_W'(w_d2) <= CMP_W'(r_b_r2);
        n_c.at_apex = (r_b_dx == '0) && (r_b_dy == '0);
        n_c.x       = w_x0;
        n_c.y       = w_y0;
        n_c.z       = '0;
        if (w_x0[CW-1]) begin
            if (!w_y0[CW-1]) begin
                n_c.x = w_y0;
                n_c.y = -w_x0;
                n_c.z = Z_QUARTER;
            end else begin
                n_c.x = -w_y0;
                n_c.y = w_x0;
                n_c.z = -Z_QUARTER;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_c <= '0;
        end else if (w_en_c) begin
            r_c <= n_c;
        end
    end

    assign o_vec = r_c;

endmodule

// ===== hdl/pios_cordic.sv =====
// Vectoring CORDIC, one micro-rotation per register stage.
`timescale 1ns / 1ps

module pios_cordic
    import pios_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  t_vec i_vec,
    output logic o_ready,
    input  logic i_ready,
    output t_vec o_vec
);

    t_vec r_stg [CORDIC_STEPS];
    t_vec w_src [CORDIC_STEPS];
    logic w_en  [CORDIC_STEPS];

    for (genvar k = 0; k < CORDIC_STEPS; k++) begin : g_step
        t_vec                 n_stg;
        logic signed [CW-1:0] w_xs, w_ys;

        if (k == 0) begin : g_first
            assign w_src[k] = i_vec;
        end else begin : g_next
            assign w_src[k] = r_stg[k-1];
        end

        if (k == CORDIC_STEPS - 1) begin : g_last_en
            assign w_en[k] = !r_stg[k].valid || i_ready;
        end else begin : g_mid_en
            assign w_en[k] = !r_stg[k].valid || w_en[k+1];
        end

        // arithmetic shift: rounds toward minus infinity
        assign w_xs = w_src[k].x >>> k;
        assign w_ys = w_src[k].y >>> k;

        always_comb begin
            n_stg = w_src[k];
            if (!w_src[k].y[CW-1]) begin
                n_stg.x = w_src[k].x + w_ys;
                n_stg.y = w_src[k].y - w_xs;
                n_stg.z = w_src[k].z + f_atan(k);
            end else begin
                n_stg.x = w_src[k].x - w_ys;
                n_stg.y = w_src[k].y + w_xs;
                n_stg.z = w_src[k].z - f_atan(k);
            end
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_stg[k] <= '0;
            end else if (w_en[k]) begin
                r_stg[k] <= n_stg;
            end
        end
    end

    assign o_ready = w_en[0];
    assign o_vec   = r_stg[CORDIC_STEPS-1];

endmodule

// ===== hdl/pios_back.sv =====
// Back stages: heading rounding, wrap against forward angle, aperture check.
`timescale 1ns / 1ps

module pios_back
    import pios_pkg::*;
(
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  t_vec                    i_vec,
    output logic                    o_ready,
    input  logic signed [FWD_W-1:0] i_forward_angle,
    input  logic [APER_W-1:0]       i_aperture_angle,
    output logic                    o_valid,
    input  logic                    i_stall,
    output logic                    o_inside_res
);

    logic                     w_en_d, w_en_e, w_en_f;

    logic                     r_d_v, r_d_in_rad;
    logic signed [DIFF_W-1:0] r_d_diff, n_d_diff;
    logic signed [Z_W-1:0]    w_zr;
    logic signed [HEAD_W-1:0] w_head;

    logic                     r_e_v, r_e_in_rad;
    logic signed [WRAP_W-1:0] r_e_wrap;
    logic signed [DIFF_W-1:0] n_e_wrap;

    logic                     r_f_v, r_f_inside;
    logic [ABS_W-1:0]         w_abs;
    logic                     n_f_inside;

    assign w_en_f  = !r_f_v || !i_stall;
    assign w_en_e  = !r_e_v || w_en_f;
    assign w_en_d  = !r_d_v || w_en_e;
    assign o_ready = w_en_d;

    // stage D: round 1/65536 to 1/256 degree (halves up), subtract forward angle
    assign w_zr     = i_vec.z + Z_ROUND;
    assign w_head   = i_vec.at_apex ? '0 : signed'(w_zr[Z_W-1:8]);
    assign n_d_diff = DIFF_W'(w_head) - DIFF_W'(i_forward_angle);

    // stage E: wrap into [-180, 180], both ends kept
    always_comb begin
        n_e_wrap = r_d_diff;
        if (r_d_diff > HALF_TURN) begin
            if (r_d_diff - FULL_TURN > HALF_TURN) n_e_wrap = r_d_diff - TWO_TURNS;
            else                                  n_e_wrap = r_d_diff - FULL_TURN;
        end else if (r_d_diff < -HALF_TURN) begin
            if (r_d_diff + FULL_TURN < -HALF_TURN) n_e_wrap = r_d_diff + TWO_TURNS;
            else                                   n_e_wrap = r_d_diff + FULL_TURN;
        end
    end

    // stage F: twice the deviation against the full aperture
    assign w_abs      = r_e_wrap[WRAP_W-1] ? ABS_W'(-r_e_wrap) : ABS_W'(r_e_wrap);
    assign n_f_inside = r_e_in_rad && (APER_W'({w_abs, 1'b0}) <= i_aperture_angle);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_d_v <= 1'b0;
            r_e_v <= 1'b0;
            r_f_v <= 1'b0;
        end else begin
            if (w_en_d) r_d_v <= i_vec.valid;
            if (w_en_e) r_e_v <= r_d_v;
            if (w_en_f) r_f_v <= r_e_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en_d) begin
            r_d_diff   <= n_d_diff;
            r_d_in_rad <= i_vec.in_rad;
        end
        if (w_en_e) begin
            r_e_wrap   <= WRAP_W'(n_e_wrap);
            r_e_in_rad <= r_d_in_rad;
        end
        if (w_en_f) begin
            r_f_inside <= n_f_inside;
        end
    end

    assign o_valid      = r_f_v;
    assign o_inside_res = r_f_inside;

endmodule

// ===== hdl/point_in_oriented_sector.sv =====
// Top level of the oriented circular sector test: configuration and pipeline.
`timescale 1ns / 1ps

// Streams points and answers, one result item per point, whether each lies in
// a circular sector set by apex, forward heading, full aperture and radius
// (coordinates in 1/256, angles in 1/256 degree). A new point is taken every
// cycle while o_stall is low, and each answer passes in order through three
// front stages (offset, squares, distance compare and quadrant
// fold), one stage per 64-bit CORDIC micro-rotation, and three back stages
// (heading rounding, wrap, aperture compare with the output register). Each
// stage holds while it is full and the stage after it is held, so empty slots
// fill up behind a stalled result and the input keeps going until the whole
// pipe is full. Registers are written through the configuration port, always
// ready; write them only with no point in flight. A point at the apex has
// heading 0, and an aperture of 360 degrees or more takes any point within
// the radius. Unknown register indexes are ignored.

module point_in_oriented_sector
    import pios_pkg::*;
(
    input  logic                         i_clk,
    input  logic                         i_rst_n,

    // point channel
    input  logic                         i_valid,
    output logic                         o_stall,
    input  logic signed [COORD_BITS-1:0] i_point_x,
    input  logic signed [COORD_BITS-1:0] i_point_y,

    // result channel
    output logic                         o_valid,
    input  logic                         i_stall,
    output logic                         o_inside_res,

    // configuration writes
    input  logic                         i_cfg_valid,
    output logic                         o_cfg_ready,
    input  logic [CFG_IDX_W-1:0]         i_cfg_index,
    input  logic [CFG_W-1:0]             i_cfg_data
);

    logic signed [COORD_BITS-1:0] r_apex_x, r_apex_y;
    logic signed [FWD_W-1:0]      r_forward_angle;
    logic [APER_W-1:0]            r_aperture_angle;
    logic [RADIUS_W-1:0]          r_sector_radius;

    logic w_front_ready, w_cordic_ready, w_back_ready;
    t_vec w_front_vec, w_cordic_vec;

    assign o_cfg_ready = 1'b1;

    // register file; values are truncated to their field widths
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_apex_x         <= '0;
            r_apex_y         <= '0;
            r_forward_angle  <= '0;
            r_aperture_angle <= '0;
            r_sector_radius  <= '0;
        end else if (i_cfg_valid && o_cfg_ready) begin
            unique case (t_reg_idx'(i_cfg_index))
                REG_APEX_X:   r_apex_x         <= signed'(i_cfg_data[COORD_BITS-1:0]);
                REG_APEX_Y:   r_apex_y         <= signed'(i_cfg_data[COORD_BITS-1:0]);
                REG_FORWARD:  r_forward_angle  <= signed'(i_cfg_data[FWD_W-1:0]);
                REG_APERTURE: r_aperture_angle <= i_cfg_data[APER_W-1:0];
                REG_RADIUS:   r_sector_radius  <= i_cfg_data[RADIUS_W-1:0];
                default: ;
            endcase
        end
    end

    // front stage A takes a point whenever it can move
    assign o_stall = !w_front_ready;

    pios_front u_front (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_valid         (i_valid),
        .i_point_x       (i_point_x),
        .i_point_y       (i_point_y),
        .i_apex_x        (r_apex_x),
        .i_apex_y        (r_apex_y),
        .i_sector_radius (r_sector_radius),
        .i_ready         (w_cordic_ready),
        .o_ready         (w_front_ready),
        .o_vec           (w_front_vec)
    );

    pios_cordic u_cordic (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_vec   (w_front_vec),
        .o_ready (w_cordic_ready),
        .i_ready (w_back_ready),
        .o_vec   (w_cordic_vec)
    );

    pios_back u_back (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_vec            (w_cordic_vec),
        .o_ready          (w_back_ready),
        .i_forward_angle  (r_forward_angle),
        .i_aperture_angle (r_aperture_angle),
        .o_valid          (o_valid),
        .i_stall          (i_stall),
        .o_inside_res     (o_inside_res)
    );

endmodule
